// ===== hw/rtl/lru_pkg.sv =====
// Shared types and constants of the LRU key-value cache.
`default_nettype none
package lru_pkg;
    localparam int ENTRIES = 16;
    localparam int IDX_W = $clog2(ENTRIES);
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam int KEY_W = 32;
    localparam int VAL_W = 32;
    localparam int CAP_W = 5;
    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);
    localparam logic FUNC_GET = 1'b0;
    localparam logic FUNC_PUT = 1'b1;
    localparam logic [VAL_W-1:0] MISS_VALUE = '1;
    localparam int QDEPTH = 2;

    typedef struct packed {
        logic             func;
        logic [KEY_W-1:0] lookup_key;
        logic [VAL_W-1:0] write_value;
    } item_t;

    typedef struct packed {
        logic             hit;
        logic [VAL_W-1:0] read_value;
        logic             evicted;
        logic [KEY_W-1:0] evicted_key;
    } result_t;
endpackage
`default_nettype wire

// ===== hw/rtl/lru_key_value_cache_top.sv =====
// Top level of the LRU key-value cache.
// One get or put per cycle unless the receiver stalls: the back part compares the key against
// all sixteen slots and updates the recency ranks combinationally; an item's result is
// registered and appears in the cycle after it leaves the two-entry input queue. Capacity
// zero acts as one, above sixteen as sixteen; write it only while the block is idle.
`default_nettype none
module lru_key_value_cache_top (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic [4:0]  cfg_wr_data,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [63:0] s_tdata,  // lookup_key[31:0], write_value[63:32]
    input  wire logic        s_tuser,  // func
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [71:0]      m_tdata,  // read_value[31:0], evicted[32], evicted_key[64:33]
    output logic             m_tuser   // hit
);
    logic [lru_pkg::CAP_W-1:0] cap_reg;
    lru_pkg::item_t            in_item, q_item;
    lru_pkg::result_t          res;
    logic                      q_valid, q_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) cap_reg <= lru_pkg::CAP_RESET;
        else if (cfg_wr_en) cap_reg <= cfg_wr_data;
    end

    assign in_item.func        = s_tuser;
    assign in_item.lookup_key  = s_tdata[31:0];
    assign in_item.write_value = s_tdata[63:32];

    lru_front u_front (
        .aclk(aclk), .aresetn(aresetn), .in_valid(s_tvalid), .in_ready(s_tready),
        .in_item(in_item), .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item)
    );

    lru_back u_back (
        .aclk(aclk), .aresetn(aresetn), .capacity(cap_reg), .q_valid(q_valid),
        .q_ready(q_ready), .q_item(q_item), .out_valid(m_tvalid), .out_ready(m_tready),
        .out_res(res)
    );

    assign m_tdata = {7'd0, res.evicted_key, res.evicted, res.read_value};
    assign m_tuser = res.hit;
endmodule
`default_nettype wire

// ===== hw/rtl/lru_front.sv =====
// Front part: a small queue that accepts items and hands them to the back part.
`default_nettype none
module lru_front (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire lru_pkg::item_t in_item,
    output logic               q_valid,
    input  wire logic          q_ready,
    output lru_pkg::item_t     q_item
);
    lru_pkg::item_t slot_reg [lru_pkg::QDEPTH];
    logic           wp_reg, wp_next, rp_reg, rp_next;
    logic [1:0]     cnt_reg, cnt_next;
    logic           push, pop;

    assign in_ready = (cnt_reg != 2'(lru_pkg::QDEPTH));
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_item   = slot_reg[rp_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;

    always_comb begin
        wp_next  = push ? ~wp_reg : wp_reg;
        rp_next  = pop ? ~rp_reg : rp_reg;
        cnt_next = cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
        if (push) slot_reg[wp_reg] <= in_item;
    end
endmodule
`default_nettype wire

// ===== hw/rtl/lru_back.sv =====
// Back part: parallel key compare, recency rank update and eviction.
`default_nettype none
module lru_back (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic [lru_pkg::CAP_W-1:0]  capacity,
    input  wire logic                       q_valid,
    output logic                            q_ready,
    input  wire lru_pkg::item_t             q_item,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output lru_pkg::result_t                out_res
);
    localparam int N = lru_pkg::ENTRIES;
    localparam int IW = lru_pkg::IDX_W;
    localparam int CW = lru_pkg::CNT_W;

    logic [lru_pkg::KEY_W-1:0] key_reg [N];
    logic [lru_pkg::VAL_W-1:0] val_reg [N];
    logic [N-1:0]              valid_reg, valid_next;
    logic [IW-1:0]             rank_reg [N];
    logic [IW-1:0]             rank_next [N];
    logic [CW-1:0]             occ_reg, occ_next;
    logic                      ov_reg;
    lru_pkg::result_t          res_reg, res_next;

    logic [N-1:0]  match, oldest, freev;
    logic          found, do_ev, fire, is_put;
    logic [IW-1:0] fidx, oidx, widx, frank;
    logic [CW-1:0] cap;
    logic          has_free;

    assign q_ready   = !ov_reg || out_ready;
    assign fire      = q_valid && q_ready;
    assign out_valid = ov_reg;
    assign out_res   = res_reg;
    assign is_put    = (q_item.func == lru_pkg::FUNC_PUT);

    always_comb begin
        if (capacity == '0) cap = CW'(1);
        else if (32'(capacity) > N) cap = CW'(N);
        else cap = CW'(capacity);
        for (int i = 0; i < N; i++) begin
            match[i] = valid_reg[i] && (key_reg[i] == q_item.lookup_key);
        end
        found = |match;
        fidx = '0;
        for (int i = N - 1; i >= 0; i--) begin
            if (match[i]) fidx = IW'(i);
        end
        frank = rank_reg[fidx];
        if (found) do_ev = is_put && (occ_reg > cap);
        else do_ev = is_put && (occ_reg >= cap);

        valid_next = valid_reg;
        occ_next   = occ_reg;
        for (int i = 0; i < N; i++) rank_next[i] = rank_reg[i];
        if (found) begin
            for (int i = 0; i < N; i++)
                if (valid_reg[i] && rank_reg[i] < frank) rank_next[i] = rank_reg[i] + 1'b1;
            rank_next[fidx] = '0;
        end
        // The victim is the least recent entry once a hit has been promoted.
        for (int i = 0; i < N; i++) begin
            oldest[i] = valid_reg[i] && (CW'(rank_next[i]) == occ_reg - CW'(1));
        end
        oidx = '0;
        for (int i = N - 1; i >= 0; i--) begin
            if (oldest[i]) oidx = IW'(i);
        end
        if (do_ev) begin
            valid_next[oidx] = 1'b0;
            rank_next[oidx]  = '0;
            occ_next         = occ_next - CW'(1);
        end
        freev = ~valid_next;
        has_free = |freev;
        widx = '0;
        for (int i = N - 1; i >= 0; i--) if (freev[i]) widx = IW'(i);
        if (is_put && !found && has_free) begin
            for (int i = 0; i < N; i++)
                if (valid_next[i]) rank_next[i] = rank_next[i] + 1'b1;
            valid_next[widx] = 1'b1;
            rank_next[widx]  = '0;
            occ_next         = occ_next + CW'(1);
        end

        res_next.hit         = found;
        res_next.read_value  = is_put ? '0 : (found ? val_reg[fidx] : lru_pkg::MISS_VALUE);
        res_next.evicted     = do_ev;
        res_next.evicted_key = do_ev ? key_reg[oidx] : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            occ_reg   <= '0;
            ov_reg    <= 1'b0;
            for (int i = 0; i < N; i++) rank_reg[i] <= '0;
        end else begin
            if (fire) begin
                valid_reg <= valid_next;
                occ_reg   <= occ_next;
                for (int i = 0; i < N; i++) rank_reg[i] <= rank_next[i];
                ov_reg    <= 1'b1;
            end else if (out_ready) begin
                ov_reg <= 1'b0;
            end
        end
        if (fire) begin
            res_reg <= res_next;
            if (is_put && found) val_reg[fidx] <= q_item.write_value;
            if (is_put && !found && has_free) begin
                key_reg[widx] <= q_item.lookup_key;
                val_reg[widx] <= q_item.write_value;
            end
        end
    end
endmodule
`default_nettype wire

// ===== hw/rtl/lru_checker.sv =====
// Port-level checker for the LRU key-value cache, bound to the top level.
`default_nettype none
module lru_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [71:0] m_tdata,
    input wire logic        m_tuser
);
    a_noev_key: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[32] |-> m_tdata[64:33] == 32'd0) else $error("key without eviction");
    a_put_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[32] |-> m_tdata[31:0] == 32'd0) else $error("eviction with read value");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result dropped");
    a_pad: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[71:65] == 7'd0) else $error("pad not zero");
endmodule

bind lru_key_value_cache_top lru_checker u_checker (
    .aclk(aclk), .aresetn(aresetn), .m_tvalid(m_tvalid), .m_tready(m_tready),
    .m_tdata(m_tdata), .m_tuser(m_tuser)
);
`default_nettype wire

// ===== dv/lru_key_value_cache_top_tb.sv =====
// Self-checking testbench of the LRU key-value cache, driven through its item streams.
`timescale 1ns / 1ps
module lru_key_value_cache_top_tb;

    localparam int RANDOM_ITEMS = 1850;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_OFF_CYCLES = 60;

    typedef struct packed {
        logic                      hit;
        logic [lru_pkg::VAL_W-1:0] read_value;
        logic                      evicted;
        logic [lru_pkg::KEY_W-1:0] evicted_key;
    } outcome_t;

    typedef struct {
        logic                      func;
        logic [lru_pkg::KEY_W-1:0] lookup_key;
        logic [lru_pkg::VAL_W-1:0] write_value;
        logic                      typed;
        outcome_t                  want;
    } directed_row_t;

    logic                       aclk = 1'b0;
    logic                       aresetn = 1'b0;
    logic                       cfg_wr_en = 1'b0;
    logic [lru_pkg::CAP_W-1:0]  cfg_wr_data = '0;
    logic                       s_tvalid = 1'b0;
    logic                       s_tready;
    logic [63:0]                s_tdata = '0;
    logic                       s_tuser = 1'b0;
    logic                       m_tvalid;
    logic                       m_tready = 1'b0;
    logic [71:0]                m_tdata;
    logic                       m_tuser;

    // Shadow of the cache contents.
    logic [lru_pkg::KEY_W-1:0]  slot_key [lru_pkg::ENTRIES];
    logic [lru_pkg::VAL_W-1:0]  slot_value [lru_pkg::ENTRIES];
    logic                       slot_valid [lru_pkg::ENTRIES];
    int unsigned                slot_rank [lru_pkg::ENTRIES];
    int unsigned                occupancy;
    int unsigned                capacity;

    outcome_t                   pending_outcomes [$];
    int unsigned                mismatches = 0;
    int unsigned                items_sent = 0;
    int unsigned                results_seen = 0;
    int unsigned                evictions_seen = 0;
    int unsigned                hold_off_len = 0;
    bit                         idle_free = 1'b0;
    bit                         timed_out = 1'b0;
    int unsigned                quiet_cycles = 0;
    logic [lru_pkg::KEY_W-1:0]  key_pool [8];

    lru_key_value_cache_top i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    always #4 aclk = ~aclk;

    function automatic logic [lru_pkg::KEY_W-1:0] drop_oldest();
        for (int i = 0; i < lru_pkg::ENTRIES; i++) begin
            if (slot_valid[i] && slot_rank[i] == occupancy - 1) begin
                slot_valid[i] = 1'b0;
                slot_rank[i] = 0;
                occupancy--;
                return slot_key[i];
            end
        end
        return '0;
    endfunction

    function automatic void promote(int s);
        for (int i = 0; i < lru_pkg::ENTRIES; i++) begin
            if (slot_valid[i] && i != s && slot_rank[i] < slot_rank[s]) begin
                slot_rank[i]++;
            end
        end
        slot_rank[s] = 0;
    endfunction

    function automatic outcome_t cache_access(logic func, logic [lru_pkg::KEY_W-1:0] key,
                                              logic [lru_pkg::VAL_W-1:0] value);
        outcome_t o;
        int found;
        int cap;
        int free_slot;
        o = '0;
        found = -1;
        free_slot = -1;
        cap = (capacity == 0) ? 1 :
              (capacity > lru_pkg::ENTRIES ? lru_pkg::ENTRIES : capacity);
        for (int i = 0; i < lru_pkg::ENTRIES; i++) begin
            if (found < 0 && slot_valid[i] && slot_key[i] == key) begin
                found = i;
            end
        end
        o.hit = (found >= 0);
        if (func == lru_pkg::FUNC_GET) begin
            if (found >= 0) begin
                o.read_value = slot_value[found];
                promote(found);
            end else begin
                o.read_value = lru_pkg::MISS_VALUE;
            end
        end else if (found >= 0) begin
            slot_value[found] = value;
            promote(found);
            if (occupancy > cap) begin
                o.evicted = 1'b1;
                o.evicted_key = drop_oldest();
            end
        end else begin
            if (occupancy >= cap || occupancy >= lru_pkg::ENTRIES) begin
                o.evicted = 1'b1;
                o.evicted_key = drop_oldest();
            end
            for (int i = lru_pkg::ENTRIES - 1; i >= 0; i--) begin
                if (!slot_valid[i]) begin
                    free_slot = i;
                end
            end
            if (free_slot >= 0) begin
                for (int j = 0; j < lru_pkg::ENTRIES; j++) begin
                    if (slot_valid[j]) begin
                        slot_rank[j]++;
                    end
                end
                slot_valid[free_slot] = 1'b1;
                slot_key[free_slot] = key;
                slot_value[free_slot] = value;
                slot_rank[free_slot] = 0;
                occupancy++;
            end
        end
        return o;
    endfunction

    task automatic send_item(logic func, logic [lru_pkg::KEY_W-1:0] key,
                             logic [lru_pkg::VAL_W-1:0] value, bit typed, outcome_t want);
        outcome_t o;
        int gap;
        if (!idle_free && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 17);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= func;
        s_tdata <= {value, key};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        o = cache_access(func, key, value);
        if (typed && o !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("directed row disagrees with prediction: typed %h predicted %h",
                         want, o);
            end
        end
        pending_outcomes.push_back(o);
        items_sent++;
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_outcomes.size() != 0 && !timed_out) @(posedge aclk);
        repeat (5) @(posedge aclk);
    endtask

    task automatic set_capacity(int unsigned value);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value[lru_pkg::CAP_W-1:0];
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        capacity = value & 5'h1f;
    endtask

    // Receiver: random stalls, one long hold-off, none in the final stretch.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_off_len > 0) begin
            m_tready <= 1'b0;
            hold_off_len <= hold_off_len - 1;
        end else if (idle_free) begin
            m_tready <= 1'b1;
        end else if (!m_tready) begin
            m_tready <= ($urandom_range(0, 3) == 0);
        end else begin
            m_tready <= ($urandom_range(0, 9) != 0);
        end
    end

    always @(posedge aclk) begin
        outcome_t got;
        outcome_t exp;
        if (aresetn && m_tvalid && m_tready) begin
            got = {m_tuser, m_tdata[31:0], m_tdata[32], m_tdata[64:33]};
            results_seen++;
            if (got.evicted) evictions_seen++;
            if (pending_outcomes.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result item %h", got);
            end else begin
                exp = pending_outcomes.pop_front();
                if (got.hit !== exp.hit || got.read_value !== exp.read_value ||
                    got.evicted !== exp.evicted || got.evicted_key !== exp.evicted_key) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("result mismatch: expected hit %0b value %h ev %0b key %h,",
                                 exp.hit, exp.read_value, exp.evicted, exp.evicted_key);
                        $display("  got hit %0b value %h ev %0b key %h",
                                 got.hit, got.read_value, got.evicted, got.evicted_key);
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            timed_out <= 1'b1;
            $display("end of test: mismatches");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        directed_row_t rows [$];
        outcome_t none;
        int unsigned caps [6];
        logic func;
        logic [lru_pkg::KEY_W-1:0] key;
        logic [lru_pkg::VAL_W-1:0] value;
        int unsigned roll;
        none = '0;
        caps = '{1, 0, 31, 3, 17, 8};
        for (int i = 0; i < lru_pkg::ENTRIES; i++) begin
            slot_valid[i] = 1'b0;
            slot_rank[i] = 0;
            slot_key[i] = '0;
            slot_value[i] = '0;
        end
        occupancy = 0;
        capacity = lru_pkg::CAP_RESET;

        // Directed rows: empty-store misses, extremes, overwrite, then eviction on a full store.
        rows.push_back('{lru_pkg::FUNC_GET, 32'h0000_0000, 32'h0, 1'b1,
                         '{1'b0, lru_pkg::MISS_VALUE, 1'b0, '0}});
        rows.push_back('{lru_pkg::FUNC_GET, 32'hffff_ffff, 32'h0, 1'b1,
                         '{1'b0, lru_pkg::MISS_VALUE, 1'b0, '0}});
        rows.push_back('{lru_pkg::FUNC_PUT, 32'hffff_ffff, 32'h7fff_ffff, 1'b1, none});
        rows.push_back('{lru_pkg::FUNC_PUT, 32'h0000_0000, 32'h8000_0000, 1'b1, none});
        rows.push_back('{lru_pkg::FUNC_GET, 32'hffff_ffff, 32'h0, 1'b1,
                         '{1'b1, 32'h7fff_ffff, 1'b0, '0}});
        rows.push_back('{lru_pkg::FUNC_GET, 32'h0000_0000, 32'h0, 1'b1,
                         '{1'b1, 32'h8000_0000, 1'b0, '0}});
        rows.push_back('{lru_pkg::FUNC_PUT, 32'h0000_0000, 32'hffff_ffff, 1'b1,
                         '{1'b1, '0, 1'b0, '0}});
        rows.push_back('{lru_pkg::FUNC_GET, 32'h0000_0000, 32'h0, 1'b1,
                         '{1'b1, 32'hffff_ffff, 1'b0, '0}});
        for (int i = 1; i <= 16; i++) begin
            rows.push_back('{lru_pkg::FUNC_PUT, 32'(i * 32'h1111_0001), 32'(i), 1'b0, none});
        end

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (rows[r]) begin
            send_item(rows[r].func, rows[r].lookup_key, rows[r].write_value,
                      rows[r].typed, rows[r].want);
        end
        wait_drained();

        for (int k = 0; k < 8; k++) key_pool[k] = $urandom;
        for (int p = 0; p < 7; p++) begin
            // The last phase returns to the full size, then lowers below occupancy mid-phase.
            if (p == 6) begin
                set_capacity(16);
            end else begin
                set_capacity(caps[p]);
            end
            if (p == 2) hold_off_len = HOLD_OFF_CYCLES * 4;
            for (int n = 0; n < RANDOM_ITEMS / 7; n++) begin
                if (p == 6 && n == RANDOM_ITEMS / 14) begin
                    wait_drained();
                    set_capacity(2);
                end
                if (p == 6 && n > RANDOM_ITEMS / 10) idle_free = 1'b1;
                roll = $urandom_range(0, 99);
                func = ($urandom_range(0, 1) == 1) ? lru_pkg::FUNC_PUT : lru_pkg::FUNC_GET;
                if (roll < 80) begin
                    key = 32'($urandom_range(0, 23)) ^ key_pool[$urandom_range(0, 7) & 1];
                end else if (roll < 90) begin
                    key = key_pool[$urandom_range(0, 7)];
                end else begin
                    key = $urandom;
                end
                value = $urandom;
                send_item(func, key, value, 1'b0, none);
            end
            wait_drained();
        end

        $display("%0d items sent, %0d results checked, %0d evictions seen,", items_sent,
                 results_seen, evictions_seen);
        $display("over capacities from zero to thirty-one, with one long receiver stall.");
        if (mismatches == 0 && pending_outcomes.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end
endmodule

// ===== files.f =====
hw/rtl/lru_pkg.sv
hw/rtl/lru_front.sv
hw/rtl/lru_back.sv
hw/rtl/lru_key_value_cache_top.sv
hw/rtl/lru_checker.sv
dv/lru_key_value_cache_top_tb.sv
